### rtl/owt_pkg.sv
// Package for the one-wire bus master: codes, register indexes, reset values
// and the types of the transaction payloads and sequencer state.
// No dependencies.
package owt_pkg;

  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [2:0] CMD_RESET     = 3'd0;
  localparam logic [2:0] CMD_WRITE     = 3'd1;
  localparam logic [2:0] CMD_READ      = 3'd2;
  localparam logic [2:0] CMD_CONVERT   = 3'd3;
  localparam logic [2:0] CMD_READ_TEMP = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESENCE_SMP  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SLOT_LOW      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_DELAY  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SLOT_HOLD     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SKIP_ROM      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CONVERT       = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_READ_SCRATCH  = 3'd7;

  localparam logic [9:0] RESET_LOW_DEFAULT    = 10'd500;
  localparam logic [7:0] PRESENCE_SMP_DEFAULT = 8'd60;
  localparam logic [3:0] SLOT_LOW_DEFAULT     = 4'd2;
  localparam logic [3:0] SAMPLE_DELAY_DEFAULT = 4'd2;
  localparam logic [7:0] SLOT_HOLD_DEFAULT    = 8'd60;
  localparam logic [7:0] SKIP_ROM_DEFAULT     = 8'hCC;
  localparam logic [7:0] CONVERT_DEFAULT      = 8'h44;
  localparam logic [7:0] READ_SCRATCH_DEFAULT = 8'hBE;

  localparam logic [2:0] LAST_BIT = 3'd7;
  localparam logic [2:0] LOW_BYTE_STEP = 3'd3;
  localparam logic [2:0] SKIP_ROM_STEP = 3'd1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_RECOV,
    PH_SLOT_LOW,
    PH_WR_HOLD,
    PH_RD_WAIT,
    PH_RD_HOLD
  } phase_e;

  typedef enum logic [1:0] {
    OP_RST,
    OP_WR,
    OP_RD
  } op_e;

  typedef struct packed {
    logic       start_req;
    logic [2:0] cmd;
    logic [7:0] write_byte;
    logic       line_in;
  } tick_item_t;

  typedef struct packed {
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic               presence_ok;
    logic [7:0]         read_byte;
    logic signed [15:0] temperature;
  } res_item_t;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [7:0] presence_smp;
    logic [3:0] slot_low;
    logic [3:0] sample_delay;
    logic [7:0] slot_hold;
    logic [7:0] skip_rom;
    logic [7:0] convert;
    logic [7:0] read_scratch;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  step;
    logic [9:0]  tick;
    logic [2:0]  bit_idx;
    logic [7:0]  shift;
    logic [7:0]  low_byte;
    logic        presence;
    logic [2:0]  cmd;
    logic [7:0]  read_hold;
    logic [15:0] temp_hold;
  } seq_t;

endpackage

### rtl/owt_if.sv
// Handshake channels of the one-wire bus master: a generic valid/ready stream
// and the register write channel. Depends on owt_pkg.
interface owt_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface owt_cfg_if ();
  logic                         valid;
  logic                         ready;
  logic [owt_pkg::CfgIdxW-1:0]  index;
  logic [owt_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/one_wire_temp_sensor_master.sv
// One-wire bus master top level: input register, single-pass sequencer step
// and result register. Depends on owt_pkg and owt_if.
//
// Each transaction on tick_i is one bus tick (sampled line level plus an
// optional command) and yields exactly one transaction on res_o with the
// open-drain drive, busy, done, presence and read data for that tick. The
// block takes one tick per clock cycle while res_o is not stalled; the whole
// sequencer update for a tick is one combinational pass between the input
// register and the result register, so a tick is held in the input register
// and its result is offered on res_o from the result register, and both sides
// may stall freely. Registers are written over cfg_i, which is always ready,
// and should only be written while no command is running.
module one_wire_temp_sensor_master (
  input  logic         clk_i,
  input  logic         rst_ni,
  owt_stream_if.sink   tick_i,
  owt_stream_if.source res_o,
  owt_cfg_if.sink      cfg_i
);
  import owt_pkg::*;

  cfg_t       cfg_q;
  seq_t       seq_q, seq_d;
  tick_item_t in_q;
  logic       in_vld_q;
  res_item_t  out_q, out_d;
  logic       out_vld_q;
  logic       proc;
  logic [9:0] dur;
  logic       last;

  function automatic op_e op_of(logic [2:0] cmd, logic [2:0] step);
    op_e op;
    if (cmd == CMD_WRITE) op = OP_WR;
    else if (cmd == CMD_READ) op = OP_RD;
    else if (cmd == CMD_RESET || step == 3'd0) op = OP_RST;
    else if (step <= SKIP_ROM_STEP + 3'd1) op = OP_WR;
    else op = OP_RD;
    return op;
  endfunction

  function automatic logic [2:0] seq_len(logic [2:0] cmd);
    logic [2:0] n;
    if (cmd == CMD_CONVERT) n = 3'd3;
    else if (cmd == CMD_READ_TEMP) n = 3'd5;
    else n = 3'd1;
    return n;
  endfunction

  function automatic seq_t start_op(seq_t s, cfg_t c);
    seq_t r;
    op_e  op;
    r  = s;
    op = op_of(s.cmd, s.step);
    r.tick    = '0;
    r.bit_idx = '0;
    if (op == OP_RST) begin
      r.phase = PH_RST_LOW;
    end else begin
      if (op == OP_WR && s.cmd != CMD_WRITE) begin
        r.shift = (s.step == SKIP_ROM_STEP) ? c.skip_rom
                : (s.cmd == CMD_CONVERT ? c.convert : c.read_scratch);
      end
      if (op == OP_RD) r.shift = '0;
      r.phase = PH_SLOT_LOW;
    end
    return r;
  endfunction

  function automatic seq_t op_done(seq_t s, cfg_t c);
    seq_t r;
    op_e  op;
    r  = s;
    op = op_of(s.cmd, s.step);
    if (op == OP_RD) begin
      if (s.cmd == CMD_READ) r.read_hold = s.shift;
      else if (s.step == LOW_BYTE_STEP) r.low_byte = s.shift;
      else r.temp_hold = {s.shift, s.low_byte};
    end
    r.step = s.step + 3'd1;
    if (r.step >= seq_len(s.cmd) || (op == OP_RST && !s.presence)) begin
      r.phase = PH_IDLE;
      r.step  = '0;
      r.tick  = '0;
    end else begin
      r = start_op(r, c);
    end
    return r;
  endfunction

  function automatic seq_t bit_done(seq_t s, cfg_t c);
    seq_t r;
    r = s;
    if (s.bit_idx >= LAST_BIT) begin
      r = op_done(s, c);
    end else begin
      r.bit_idx = s.bit_idx + 3'd1;
      r.tick    = '0;
      r.phase   = PH_SLOT_LOW;
    end
    return r;
  endfunction

  assign proc         = in_vld_q && (!out_vld_q || res_o.ready);
  assign tick_i.ready = !in_vld_q || proc;
  assign cfg_i.ready  = 1'b1;
  assign res_o.valid  = out_vld_q;
  assign res_o.data   = out_q;

  always_comb begin
    seq_d = seq_q;
    out_d = '0;
    if (seq_q.phase == PH_IDLE && in_q.start_req && in_q.cmd <= CMD_READ_TEMP) begin
      seq_d.cmd   = in_q.cmd;
      seq_d.step  = '0;
      seq_d.shift = in_q.write_byte;
      seq_d       = start_op(seq_d, cfg_q);
    end

    unique case (seq_d.phase)
      PH_RST_LOW:  dur = cfg_q.reset_low;
      PH_RST_WAIT: dur = {2'b00, cfg_q.presence_smp};
      PH_SLOT_LOW: dur = {6'd0, cfg_q.slot_low};
      PH_RD_WAIT:  dur = {6'd0, cfg_q.sample_delay};
      default:     dur = {2'b00, cfg_q.slot_hold};
    endcase
    last = ({1'b0, seq_d.tick} + 11'd1) >= {1'b0, dur};

    if (seq_d.phase != PH_IDLE) begin
      out_d.busy_res = 1'b1;
      if (seq_d.phase != PH_RST_RECOV) begin
        seq_d.tick = last ? '0 : seq_d.tick + 10'd1;
      end
      unique case (seq_d.phase)
        PH_RST_LOW: begin
          out_d.drive_low = 1'b1;
          if (last) seq_d.phase = PH_RST_WAIT;
        end
        PH_RST_WAIT: begin
          if (last) begin
            seq_d.presence = !in_q.line_in;
            seq_d.phase    = PH_RST_RECOV;
          end
        end
        PH_RST_RECOV: begin
          if (in_q.line_in) seq_d = op_done(seq_d, cfg_q);
        end
        PH_SLOT_LOW: begin
          out_d.drive_low = 1'b1;
          if (last) begin
            seq_d.phase = (op_of(seq_d.cmd, seq_d.step) == OP_WR) ? PH_WR_HOLD : PH_RD_WAIT;
          end
        end
        PH_WR_HOLD: begin
          out_d.drive_low = !seq_d.shift[0];
          if (last) begin
            seq_d.shift = {1'b0, seq_d.shift[7:1]};
            seq_d       = bit_done(seq_d, cfg_q);
          end
        end
        PH_RD_WAIT: begin
          if (last) begin
            seq_d.shift = {in_q.line_in, seq_d.shift[7:1]};
            seq_d.phase = PH_RD_HOLD;
          end
        end
        PH_RD_HOLD: begin
          if (last) seq_d = bit_done(seq_d, cfg_q);
        end
        PH_IDLE: begin
        end
      endcase
      out_d.done_res = (seq_d.phase == PH_IDLE);
    end
    out_d.presence_ok = seq_d.presence;
    out_d.read_byte   = seq_d.read_hold;
    out_d.temperature = seq_d.temp_hold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low    <= RESET_LOW_DEFAULT;
      cfg_q.presence_smp <= PRESENCE_SMP_DEFAULT;
      cfg_q.slot_low     <= SLOT_LOW_DEFAULT;
      cfg_q.sample_delay <= SAMPLE_DELAY_DEFAULT;
      cfg_q.slot_hold    <= SLOT_HOLD_DEFAULT;
      cfg_q.skip_rom     <= SKIP_ROM_DEFAULT;
      cfg_q.convert      <= CONVERT_DEFAULT;
      cfg_q.read_scratch <= READ_SCRATCH_DEFAULT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RESET_LOW:    cfg_q.reset_low    <= cfg_i.data;
        REG_PRESENCE_SMP: cfg_q.presence_smp <= cfg_i.data[7:0];
        REG_SLOT_LOW:     cfg_q.slot_low     <= cfg_i.data[3:0];
        REG_SAMPLE_DELAY: cfg_q.sample_delay <= cfg_i.data[3:0];
        REG_SLOT_HOLD:    cfg_q.slot_hold    <= cfg_i.data[7:0];
        REG_SKIP_ROM:     cfg_q.skip_rom     <= cfg_i.data[7:0];
        REG_CONVERT:      cfg_q.convert      <= cfg_i.data[7:0];
        REG_READ_SCRATCH: cfg_q.read_scratch <= cfg_i.data[7:0];
      endcase
    end
  end

  // all-zero state is the idle phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= '0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (tick_i.ready) in_vld_q <= tick_i.valid;
      if (proc) begin
        seq_q     <= seq_d;
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i.ready) in_q <= tick_i.data;
    if (proc) out_q <= out_d;
  end

endmodule

### rtl/owt_checker.sv
// Port-level checks for the one-wire bus master, attached by bind.
// Depends on owt_pkg and the top level one_wire_temp_sensor_master.
module owt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               tick_ready_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input owt_pkg::res_item_t res_data_i
);
  import owt_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result changed while stalled");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.done_res |-> res_data_i.busy_res)
    else $error("done outside a command");

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.drive_low |-> res_data_i.busy_res)
    else $error("bus driven while idle");

  a_tick_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> tick_ready_i)
    else $error("tick stalled with empty result stage");

endmodule

bind one_wire_temp_sensor_master owt_checker u_owt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .tick_ready_i (tick_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_data_i   (res_o.data)
);

### verif/one_wire_temp_sensor_master_tb.sv
// Self-checking testbench for one_wire_temp_sensor_master: a directed table of bus
// ticks, then randomised command sequences under several register settings.
// Depends on owt_pkg and the owt_stream_if / owt_cfg_if interfaces.
module one_wire_temp_sensor_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import owt_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam int         SQUEEZE_CYCLES = 400;

  typedef enum {CFG_MIN, CFG_ZERO, CFG_SMALL} cfg_kind_e;

  typedef struct {
    logic       start;
    logic [2:0] cmd;
    logic [7:0] wb;
    logic       line;
    int         reps;
    bit         typed;
    res_item_t  want;
  } drill_t;

  localparam res_item_t QUIET     = '0;
  localparam res_item_t RST_PULSE = '{drive_low: 1'b1, busy_res: 1'b1, default: '0};

  logic clk;
  logic rst_n;

  owt_stream_if #(.T(tick_item_t)) tick_if ();
  owt_stream_if #(.T(res_item_t))  res_if ();
  owt_cfg_if                       cfg_if ();

  one_wire_temp_sensor_master u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .tick_i(tick_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // sequencer mirror
  cfg_t        bus_cfg;
  phase_e      ph;
  logic [2:0]  step;
  logic [2:0]  bit_no;
  logic [2:0]  cur_cmd;
  logic [9:0]  tcnt;
  logic [7:0]  shreg;
  logic [7:0]  low_keep;
  logic [7:0]  rd_keep;
  logic [15:0] temp_keep;
  logic        pres;

  res_item_t   expected_q[$];
  drill_t      drills[$];
  int          errors;
  int          res_seen;
  bit          calm;
  bit          squeeze_req;
  bit          device_here;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (errors < 100)
      $display("ERROR result %0d %s: got %0h, want %0h", res_seen, what, got, want);
    errors++;
  endtask

  function automatic op_e op_kind(logic [2:0] c, logic [2:0] s);
    if (c == CMD_WRITE) return OP_WR;
    if (c == CMD_READ) return OP_RD;
    if (c == CMD_RESET || s == 3'd0) return OP_RST;
    if (s < LOW_BYTE_STEP) return OP_WR;
    return OP_RD;
  endfunction

  function automatic logic [2:0] steps_of(logic [2:0] c);
    if (c == CMD_CONVERT) return 3'd3;
    if (c == CMD_READ_TEMP) return 3'd5;
    return 3'd1;
  endfunction

  function automatic void model_reset();
    bus_cfg   = '{RESET_LOW_DEFAULT, PRESENCE_SMP_DEFAULT, SLOT_LOW_DEFAULT,
                  SAMPLE_DELAY_DEFAULT, SLOT_HOLD_DEFAULT, SKIP_ROM_DEFAULT,
                  CONVERT_DEFAULT, READ_SCRATCH_DEFAULT};
    ph        = PH_IDLE;
    step      = '0;
    bit_no    = '0;
    cur_cmd   = '0;
    tcnt      = '0;
    shreg     = '0;
    low_keep  = '0;
    rd_keep   = '0;
    temp_keep = '0;
    pres      = 1'b0;
  endfunction

  function automatic void begin_op();
    op_e op;
    op     = op_kind(cur_cmd, step);
    tcnt   = '0;
    bit_no = '0;
    if (op == OP_RST) begin
      ph = PH_RST_LOW;
      return;
    end
    if (op == OP_WR && cur_cmd != CMD_WRITE)
      shreg = (step == SKIP_ROM_STEP) ? bus_cfg.skip_rom
            : (cur_cmd == CMD_CONVERT ? bus_cfg.convert : bus_cfg.read_scratch);
    if (op == OP_RD) shreg = '0;
    ph = PH_SLOT_LOW;
  endfunction

  function automatic bit end_op();
    op_e op;
    op = op_kind(cur_cmd, step);
    if (op == OP_RD) begin
      if (cur_cmd == CMD_READ) rd_keep = shreg;
      else if (step == LOW_BYTE_STEP) low_keep = shreg;
      else temp_keep = {shreg, low_keep};
    end
    step = step + 3'd1;
    if (step >= steps_of(cur_cmd) || (op == OP_RST && !pres)) begin
      ph   = PH_IDLE;
      step = '0;
      tcnt = '0;
      return 1'b1;
    end
    begin_op();
    return 1'b0;
  endfunction

  function automatic bit end_bit();
    if (bit_no >= LAST_BIT) return end_op();
    bit_no = bit_no + 3'd1;
    tcnt   = '0;
    ph     = PH_SLOT_LOW;
    return 1'b0;
  endfunction

  // a register of 0 behaves as 1
  function automatic bit part_over(int dur);
    if (int'(tcnt) + 1 >= dur) begin
      tcnt = '0;
      return 1'b1;
    end
    tcnt = tcnt + 10'd1;
    return 1'b0;
  endfunction

  function automatic res_item_t predict_tick(tick_item_t t);
    res_item_t r;
    r = '0;
    if (ph == PH_IDLE && t.start_req && t.cmd <= CMD_READ_TEMP) begin
      cur_cmd = t.cmd;
      step    = '0;
      shreg   = t.write_byte;
      begin_op();
    end
    if (ph != PH_IDLE) begin
      r.busy_res = 1'b1;
      case (ph)
        PH_RST_LOW: begin
          r.drive_low = 1'b1;
          if (part_over(bus_cfg.reset_low)) ph = PH_RST_WAIT;
        end
        PH_RST_WAIT: begin
          if (part_over(bus_cfg.presence_smp)) begin
            pres = !t.line_in;
            ph   = PH_RST_RECOV;
          end
        end
        PH_RST_RECOV: begin
          if (t.line_in) r.done_res = end_op();
        end
        PH_SLOT_LOW: begin
          r.drive_low = 1'b1;
          if (part_over(bus_cfg.slot_low))
            ph = (op_kind(cur_cmd, step) == OP_WR) ? PH_WR_HOLD : PH_RD_WAIT;
        end
        PH_WR_HOLD: begin
          r.drive_low = !shreg[0];
          if (part_over(bus_cfg.slot_hold)) begin
            shreg      = shreg >> 1;
            r.done_res = end_bit();
          end
        end
        PH_RD_WAIT: begin
          if (part_over(bus_cfg.sample_delay)) begin
            shreg = {t.line_in, shreg[7:1]};
            ph    = PH_RD_HOLD;
          end
        end
        default: begin
          if (part_over(bus_cfg.slot_hold)) r.done_res = end_bit();
        end
      endcase
    end
    r.presence_ok = pres;
    r.read_byte   = rd_keep;
    r.temperature = temp_keep;
    return r;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    case (idx)
      REG_RESET_LOW:    bus_cfg.reset_low    = d[9:0];
      REG_PRESENCE_SMP: bus_cfg.presence_smp = d[7:0];
      REG_SLOT_LOW:     bus_cfg.slot_low     = d[3:0];
      REG_SAMPLE_DELAY: bus_cfg.sample_delay = d[3:0];
      REG_SLOT_HOLD:    bus_cfg.slot_hold    = d[7:0];
      REG_SKIP_ROM:     bus_cfg.skip_rom     = d[7:0];
      REG_CONVERT:      bus_cfg.convert      = d[7:0];
      default:          bus_cfg.read_scratch = d[7:0];
    endcase
  endfunction

  function automatic cfg_t pick_cfg(cfg_kind_e k);
    cfg_t c;
    c.skip_rom     = 8'($urandom);
    c.convert      = 8'($urandom);
    c.read_scratch = 8'($urandom);
    case (k)
      CFG_MIN: begin
        c = '{10'd1, 8'd1, 4'd1, 4'd1, 8'd1, 8'h00, 8'hFF, 8'h0F};
      end
      CFG_ZERO: begin
        c.reset_low    = '0;
        c.presence_smp = '0;
        c.slot_low     = '0;
        c.sample_delay = '0;
        c.slot_hold    = '0;
      end
      default: begin
        c.reset_low    = 10'($urandom_range(1, 8));
        c.presence_smp = 8'($urandom_range(1, 6));
        c.slot_low     = 4'($urandom_range(1, 4));
        c.sample_delay = 4'($urandom_range(1, 4));
        c.slot_hold    = 8'($urandom_range(1, 6));
      end
    endcase
    return c;
  endfunction

  // valid stays high across back-to-back writes; the caller lowers it
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg(idx, d);
  endtask

  task automatic load_cfg(cfg_t c);
    logic [CfgDataW-1:0] pad;
    pad = CfgDataW'($urandom);
    write_reg(REG_RESET_LOW, c.reset_low);
    write_reg(REG_PRESENCE_SMP, {pad[9:8], c.presence_smp});
    write_reg(REG_SLOT_LOW, {pad[9:4], c.slot_low});
    write_reg(REG_SAMPLE_DELAY, {pad[5:0], c.sample_delay});
    write_reg(REG_SLOT_HOLD, {pad[1:0], c.slot_hold});
    write_reg(REG_SKIP_ROM, {pad[3:2], c.skip_rom});
    write_reg(REG_CONVERT, {pad[5:4], c.convert});
    write_reg(REG_READ_SCRATCH, {pad[7:6], c.read_scratch});
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_tick(tick_item_t t, bit typed, res_item_t want);
    int gap;
    gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.valid <= 1'b1;
    tick_if.data  <= t;
    do @(posedge clk); while (!tick_if.ready);
    if (typed) begin
      void'(predict_tick(t));
      expected_q.push_back(want);
    end else begin
      expected_q.push_back(predict_tick(t));
    end
  endtask

  // line level follows what a device on the bus would plausibly do
  function automatic tick_item_t next_tick();
    tick_item_t t;
    t.write_byte = 8'($urandom);
    t.start_req  = 1'($urandom);
    t.cmd        = 3'($urandom);
    t.line_in    = 1'($urandom);
    if (ph == PH_IDLE) begin
      t.start_req = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) t.cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
      else t.cmd = 3'($urandom_range(CMD_RESET, CMD_READ_TEMP));
      device_here = ($urandom_range(0, 4) != 0);
    end else if (ph == PH_RST_WAIT) begin
      t.line_in = !device_here;
    end else if (ph == PH_RST_RECOV) begin
      t.line_in = ($urandom_range(0, 3) != 0);
    end
    return t;
  endfunction

  task automatic finish_cmd();
    while (ph != PH_IDLE) send_tick(next_tick(), 1'b0, QUIET);
  endtask

  task automatic settle();
    tick_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic void add_drill(logic start, logic [2:0] cmd, logic [7:0] wb,
                                    logic line, int reps, bit typed = 1'b0,
                                    res_item_t want = '0);
    drill_t d;
    d = '{start, cmd, wb, line, reps, typed, want};
    drills.push_back(d);
  endfunction

  task automatic run_drills();
    tick_item_t t;
    foreach (drills[i]) begin
      t = '{drills[i].start, drills[i].cmd, drills[i].wb, drills[i].line};
      repeat (drills[i].reps) send_tick(t, drills[i].typed, drills[i].want);
    end
    drills.delete();
    finish_cmd();
  endtask

  task automatic run_phase(cfg_kind_e k, int n, bit squeeze);
    settle();
    load_cfg(pick_cfg(k));
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == 40) squeeze_req = 1'b1;
      send_tick(next_tick(), 1'b0, QUIET);
    end
    finish_cmd();
  endtask

  initial begin : res_backpressure
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall_left  = SQUEEZE_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_res
    res_item_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", '0, '0);
      end else begin
        want = expected_q.pop_front();
        if (res_if.data.drive_low !== want.drive_low)
          report_mismatch("drive_low", res_if.data.drive_low, want.drive_low);
        if (res_if.data.busy_res !== want.busy_res)
          report_mismatch("busy_res", res_if.data.busy_res, want.busy_res);
        if (res_if.data.done_res !== want.done_res)
          report_mismatch("done_res", res_if.data.done_res, want.done_res);
        if (res_if.data.presence_ok !== want.presence_ok)
          report_mismatch("presence_ok", res_if.data.presence_ok, want.presence_ok);
        if (res_if.data.read_byte !== want.read_byte)
          report_mismatch("read_byte", res_if.data.read_byte, want.read_byte);
        if (res_if.data.temperature !== want.temperature)
          report_mismatch("temperature", res_if.data.temperature, want.temperature);
      end
      res_seen++;
    end
  end

  initial begin
    errors        = 0;
    res_seen      = 0;
    calm          = 1'b0;
    squeeze_req   = 1'b0;
    device_here   = 1'b1;
    rst_n         <= 1'b0;
    tick_if.valid <= 1'b0;
    tick_if.data  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    model_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, unknown commands
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b1, 1, 1'b1, QUIET);
    add_drill(1'b0, CMD_READ_TEMP, 8'hFF, 1'b0, 1, 1'b1, QUIET);
    add_drill(1'b1, CMD_SPARE_A, 8'h00, 1'b1, 1, 1'b1, QUIET);
    add_drill(1'b1, CMD_SPARE_B, 8'hFF, 1'b0, 1, 1'b1, QUIET);
    add_drill(1'b1, CMD_SPARE_C, 8'h5A, 1'b1, 1, 1'b1, QUIET);
    run_drills();

    // shortest timings: reset pulse, launch while busy, presence, stuck bus,
    // byte extremes, temperature signs
    settle();
    load_cfg(pick_cfg(CFG_MIN));
    add_drill(1'b1, CMD_RESET, 8'h00, 1'b0, 1, 1'b1, RST_PULSE);
    add_drill(1'b1, CMD_READ_TEMP, 8'h00, 1'b0, 1);
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b0, 3);
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b1, 1);
    add_drill(1'b1, CMD_WRITE, 8'h00, 1'b1, 17);
    add_drill(1'b1, CMD_WRITE, 8'hFF, 1'b0, 17);
    add_drill(1'b1, CMD_READ, 8'h00, 1'b1, 25);
    add_drill(1'b1, CMD_READ, 8'hFF, 1'b0, 25);
    add_drill(1'b1, CMD_CONVERT, 8'h00, 1'b0, 2);
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b1, 34);
    add_drill(1'b1, CMD_READ_TEMP, 8'h00, 1'b0, 2);
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b1, 33);
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b1, 24);
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b1, 25);
    add_drill(1'b1, CMD_READ_TEMP, 8'h00, 1'b0, 2);
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b1, 33);
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b0, 24);
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b0, 12);
    add_drill(1'b0, CMD_RESET, 8'h00, 1'b1, 13);
    add_drill(1'b1, CMD_READ_TEMP, 8'h00, 1'b1, 3);
    add_drill(1'b1, CMD_WRITE, 8'hA5, 1'b1, 17);
    run_drills();

    run_phase(CFG_SMALL, 120, 1'b0);
    run_phase(CFG_ZERO, 80, 1'b0);
    run_phase(CFG_SMALL, 100, 1'b1);
    calm = 1'b1;
    run_phase(CFG_MIN, 80, 1'b0);

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
